### src/exponential_backoff_jitter_defines.svh
// Assertion macros for the checker of the backoff block.
// Depends on nothing; included by the assertion checker.
`ifndef EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH
`define EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EBJ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EBJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ebj_pkg.sv
// Shared constants, codes and the xorshift step of the backoff block.
// Depends on nothing; used by the interfaces and all modules.
package ebj_pkg;

	localparam int DATA_W    = 32;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_CNT_W = $clog2(DATA_W + 1);

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_FAILURE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SUCCESS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POLL    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED      = 2'd2;

	localparam logic [DATA_W-1:0] SEED_DEFAULT  = 32'h9e37_79b9;
	localparam logic [DATA_W-1:0] ZERO_WORD_SUB = 32'h6d2b_79f5;

	localparam int XS_SHIFT_A = 13;
	localparam int XS_SHIFT_B = 17;
	localparam int XS_SHIFT_C = 5;

	typedef logic [DATA_W-1:0] word_t;

	// One xorshift32 step; a zero word is replaced before the shifts.
	function automatic word_t xorshift_step(input word_t w);
		word_t x;
		x = (w == '0) ? ZERO_WORD_SUB : w;
		x = x ^ (x << XS_SHIFT_A);
		x = x ^ (x >> XS_SHIFT_B);
		x = x ^ (x << XS_SHIFT_C);
		return x;
	endfunction

	// Seed selection used at restart.
	function automatic word_t seed_select(input word_t s);
		return (s == '0) ? SEED_DEFAULT : s;
	endfunction

endpackage

### src/ebj_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on ebj_pkg.
interface ebj_item_if;
	import ebj_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	word_t             now_time;
	modport source (output valid, output kind, output now_time, input ready);
	modport sink (input valid, input kind, input now_time, output ready);
endinterface

interface ebj_result_if;
	import ebj_pkg::*;
	logic  valid;
	logic  ready;
	logic  ready_res;
	word_t deadline;
	word_t failures;
	modport source (output valid, output ready_res, output deadline, output failures,
		input ready);
	modport sink (input valid, input ready_res, input deadline, input failures,
		output ready);
endinterface

interface ebj_cfg_if;
	import ebj_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	word_t                data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### src/ebj_divider.sv
// Iterative restoring modulo unit: one quotient bit per cycle.
// Depends on ebj_pkg.
module ebj_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  ebj_pkg::word_t            dividend,
	input  logic [ebj_pkg::DATA_W:0]  divisor,
	output logic                      done,
	output ebj_pkg::word_t            remainder
);
	import ebj_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	word_t                rem_q;
	word_t                dvd_q;
	logic [DATA_W:0]      dvs_q;
	logic [DATA_W:0]      trial;
	logic                 fits;

	// The partial remainder stays below the divisor, so it fits DATA_W bits.
	assign trial = {rem_q, dvd_q[DATA_W-1]};
	assign fits  = (trial >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(DATA_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (fits) begin
				rem_q <= DATA_W'(trial - dvs_q);
			end else begin
				rem_q <= trial[DATA_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

### src/exponential_backoff_jitter.sv
// Exponential backoff with full jitter. An item is taken only while the block is idle,
// and each item gives exactly one result. Success, poll and restart items go straight
// to the done state and then to the result register. A failure with a nonzero effective
// cap goes through prep, the restoring modulo unit that retires one bit per cycle,
// fin and upd; a failure whose effective cap is zero skips the modulo unit. The result
// register lets a new item be taken while the previous result still waits.
// Configuration writes are always taken and min/max act at once, also on an item in
// progress; the seed is loaded into the generator only by a restart.
module exponential_backoff_jitter (
	input  logic clk,
	input  logic arst_n,
	ebj_item_if.sink     item,
	ebj_result_if.source result,
	ebj_cfg_if.sink      cfg
);
	import ebj_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;

	word_t min_q, max_q, seed_q;
	word_t cap_q, retry_q, count_q, rng_q;
	word_t now_q, jit_q;

	logic  out_valid_q;
	logic  out_ready_res_q;
	word_t out_deadline_q;
	word_t out_failures_q;

	word_t           top;
	word_t           cap_sel;
	word_t           cap_eff;
	word_t           rng_next;
	word_t           cap_dbl;
	word_t           diff;
	logic [DATA_W:0] sum;
	logic            div_start;
	logic            div_done;
	word_t           div_rem;
	logic            item_xfer;
	logic            out_free;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_xfer  = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign top      = (max_q < min_q) ? min_q : max_q;
	assign cap_sel  = (cap_q == '0) ? min_q : cap_q;
	assign cap_eff  = (cap_sel > top) ? top : cap_sel;
	assign rng_next = xorshift_step(rng_q);
	assign cap_dbl  = cap_q << 1;
	assign sum      = {1'b0, now_q} + {1'b0, jit_q};
	assign diff     = now_q - retry_q;

	assign div_start = (state_q == ST_PREP) && (cap_eff != '0);

	ebj_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rng_next),
		.divisor   ({1'b0, cap_eff} + (DATA_W + 1)'(1)),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '0;
			max_q  <= '0;
			seed_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MIN_DELAY: min_q  <= cfg.data;
				REG_MAX_DELAY: max_q  <= cfg.data;
				REG_SEED:      seed_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= '0;
			retry_q <= '0;
			count_q <= '0;
			rng_q   <= SEED_DEFAULT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						unique case (item.kind)
							KIND_FAILURE: state_q <= ST_PREP;
							KIND_SUCCESS: begin
								cap_q   <= min_q;
								retry_q <= '0;
								count_q <= '0;
								state_q <= ST_DONE;
							end
							KIND_POLL: state_q <= ST_DONE;
							KIND_RESTART: begin
								cap_q   <= min_q;
								retry_q <= '0;
								count_q <= '0;
								rng_q   <= seed_select(seed_q);
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_PREP: begin
					if (div_start) begin
						rng_q   <= rng_next;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_UPD;
				ST_UPD: begin
					retry_q <= sum[DATA_W] ? '1 : sum[DATA_W-1:0];
					count_q <= count_q + 1'b1;
					// Doubling cannot overflow here since cap is below half of top.
					if (cap_q < (top >> 1)) begin
						cap_q <= (cap_dbl < min_q) ? top : cap_dbl;
					end else begin
						cap_q <= top;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item timestamp and jitter working register.
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			now_q <= item.now_time;
		end
		if (state_q == ST_PREP) begin
			jit_q <= '0;
		end else if (state_q == ST_DIV && div_done) begin
			jit_q <= div_rem;
		end else if (state_q == ST_FIN && jit_q < min_q) begin
			jit_q <= min_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_ready_res_q <= !diff[DATA_W-1];
			out_deadline_q  <= retry_q;
			out_failures_q  <= count_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.ready_res = out_ready_res_q;
	assign result.deadline  = out_deadline_q;
	assign result.failures  = out_failures_q;

endmodule

### src/ebj_checker.sv
// Port-level assertions for the backoff block and the bind that attaches them.
// Depends on ebj_pkg and exponential_backoff_jitter_defines.svh.
`include "exponential_backoff_jitter_defines.svh"

module ebj_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_ready,
	input logic           result_valid,
	input logic           result_ready,
	input logic           result_ready_res,
	input ebj_pkg::word_t result_deadline,
	input ebj_pkg::word_t result_failures,
	input logic           cfg_valid,
	input logic           cfg_ready
);
	import ebj_pkg::*;

	// The block works on one item at a time, so it is busy right after a transfer.
	`EBJ_ASSERT_NEXT(a_busy_after_item, clk, arst_n, item_valid && item_ready, !item_ready, "ready stayed high after an item transfer")

	// A new result only appears after an item has been taken.
	`EBJ_ASSERT_NOW(a_result_needs_item, clk, arst_n, $rose(result_valid), !$past(item_ready), "result appeared while the block was idle")

	// Configuration writes are never stalled.
	`EBJ_ASSERT_NOW(a_cfg_always_ready, clk, arst_n, cfg_valid, cfg_ready, "configuration write was stalled")

	// A stalled result holds its payload.
	`EBJ_ASSERT_NEXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_ready_res) && $stable(result_deadline) && $stable(result_failures), "stalled result changed")

endmodule

bind exponential_backoff_jitter ebj_checker u_ebj_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.result_ready_res (result.ready_res),
	.result_deadline  (result.deadline),
	.result_failures  (result.failures),
	.cfg_valid        (cfg.valid),
	.cfg_ready        (cfg.ready)
);
